FILE: rtl/mps_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants for the multi-rate poll scheduler
// no dependencies; imported by every rtl file of the block

package mps_pkg;

    localparam int MPS_MAX_ADDRESS   = 32;
    localparam int MPS_SLOTS_PER_ROW = 4;
    localparam int ROW_COUNT         = 7;
    localparam int ROW_W             = 3;
    localparam int SLOT_BYTES        = 4;
    localparam int CFG_W             = 32;
    localparam int CFG_INDEX_W       = 3;
    localparam int ADDR_W            = 8;
    localparam int DEV_W             = 6;
    localparam int COUNT_W           = 6;
    localparam int TICK_W            = 10;

    // row periods in ticks, row 0 runs on every tick
    localparam int ROW1_PERIOD = 2;
    localparam int ROW2_PERIOD = 6;
    localparam int ROW3_PERIOD = 12;
    localparam int ROW4_PERIOD = 60;
    localparam int ROW5_PERIOD = 120;
    localparam int ROW6_PERIOD = 600;

    // rows followed by an extra action
    localparam logic [ROW_W-1:0] ROW_CMD  = 3'd4;
    localparam logic [ROW_W-1:0] ROW_PLUG = 3'd5;
    localparam logic [ROW_W-1:0] ROW_SCAN = 3'd6;
    localparam logic [ROW_W-1:0] ROW_LAST = 3'd6;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_PRESENT = 2'd1,
        FUNC_ABSENT  = 2'd2,
        FUNC_NEXT    = 2'd3
    } mps_func_t;

    typedef enum logic [2:0] {
        KIND_POLL = 3'd0,
        KIND_CMD  = 3'd1,
        KIND_PLUG = 3'd2,
        KIND_SCAN = 3'd3,
        KIND_NEXT = 3'd4,
        KIND_NONE = 3'd5
    } mps_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_TAIL,
        ST_SEEK,
        ST_FLUSH
    } mps_state_t;

    typedef struct packed {
        mps_func_t         func;
        logic [ADDR_W-1:0] addr;
    } mps_in_t;

    typedef struct packed {
        mps_kind_t          kind;
        logic [DEV_W-1:0]   device;
        logic               cmd_slot;
        logic [COUNT_W-1:0] device_count;
        logic               last;
    } mps_out_t;

    // presence update from the sequencer
    typedef struct packed {
        logic              en;
        logic              set;
        logic [ADDR_W-1:0] addr;
    } mps_mark_t;

    // answer of the shared address probe
    typedef struct packed {
        logic in_range;
        logic hit;
    } mps_probe_t;

    typedef logic [ROW_COUNT-1:0][CFG_W-1:0] row_bank_t;

endpackage

FILE: rtl/mps_presence.sv
`timescale 1ns / 1ps
// presence bitmap, device count and the shared address probe
// depends on mps_pkg

module mps_presence #(
    parameter int MAX_ADDRESS = mps_pkg::MPS_MAX_ADDRESS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mps_pkg::mps_mark_t              mark,
    input  logic [mps_pkg::ADDR_W-1:0]      probe_addr,
    output mps_pkg::mps_probe_t             probe,
    output logic [mps_pkg::COUNT_W-1:0]     present_count
);
    import mps_pkg::*;

    localparam int AW = $clog2(MAX_ADDRESS + 1);

    logic [MAX_ADDRESS:0] map_reg;
    logic [MAX_ADDRESS:0] map_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 mark_in_range;
    logic                 mark_bit;
    logic [AW-1:0]        mark_idx;
    logic [AW-1:0]        probe_idx;

    assign mark_idx      = mark.addr[AW-1:0];
    assign mark_in_range = (mark.addr != '0) && (mark.addr <= ADDR_W'(MAX_ADDRESS));
    assign mark_bit      = map_reg[mark_idx];

    // address 0 and anything above the top address never count as present
    assign probe_idx      = probe_addr[AW-1:0];
    assign probe.in_range = (probe_addr != '0) && (probe_addr <= ADDR_W'(MAX_ADDRESS));
    assign probe.hit      = probe.in_range && map_reg[probe_idx];

    always_comb
    begin
        map_next   = map_reg;
        count_next = count_reg;
        if (mark.en && mark_in_range)
        begin
            if (mark.set && !mark_bit)
            begin
                map_next[mark_idx] = 1'b1;
                count_next         = count_reg + COUNT_W'(1);
            end
            else if (!mark.set && mark_bit)
            begin
                map_next[mark_idx] = 1'b0;
                count_next         = count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            map_reg   <= map_next;
            count_reg <= count_next;
        end
    end

    assign present_count = count_reg;

endmodule

FILE: rtl/mps_seq.sv
`timescale 1ns / 1ps
// sequencer: walks the rate table and the presence search through the shared probe,
// holds tick counters, cursor, one pending result and the output register
// depends on mps_pkg

module mps_seq #(
    parameter int MAX_ADDRESS   = mps_pkg::MPS_MAX_ADDRESS,
    parameter int SLOTS_PER_ROW = mps_pkg::MPS_SLOTS_PER_ROW
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mps_pkg::mps_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mps_pkg::mps_out_t               out_data,
    input  mps_pkg::row_bank_t              row_slots,
    input  logic [mps_pkg::COUNT_W-1:0]     present_count,
    output mps_pkg::mps_mark_t              mark,
    output logic [mps_pkg::ADDR_W-1:0]      probe_addr,
    input  mps_pkg::mps_probe_t             probe
);
    import mps_pkg::*;

    localparam int AW     = $clog2(MAX_ADDRESS + 1);
    localparam int SLOT_W = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
    localparam int R1_W   = $clog2(ROW1_PERIOD);
    localparam int R2_W   = $clog2(ROW2_PERIOD);
    localparam int R3_W   = $clog2(ROW3_PERIOD);
    localparam int R4_W   = $clog2(ROW4_PERIOD);
    localparam int R5_W   = $clog2(ROW5_PERIOD);

    // after the longest row fires the count restarts at two
    localparam int RESTART = 2;
    localparam logic [R1_W-1:0] R1_RESTART = R1_W'(RESTART % ROW1_PERIOD);
    localparam logic [R2_W-1:0] R2_RESTART = R2_W'(RESTART % ROW2_PERIOD);
    localparam logic [R3_W-1:0] R3_RESTART = R3_W'(RESTART % ROW3_PERIOD);
    localparam logic [R4_W-1:0] R4_RESTART = R4_W'(RESTART % ROW4_PERIOD);
    localparam logic [R5_W-1:0] R5_RESTART = R5_W'(RESTART % ROW5_PERIOD);

    mps_state_t         state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      cursor_reg, cursor_next;
    logic               toggle_reg, toggle_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [R1_W-1:0]    r1_reg, r1_next;
    logic [R2_W-1:0]    r2_reg, r2_next;
    logic [R3_W-1:0]    r3_reg, r3_next;
    logic [R4_W-1:0]    r4_reg, r4_next;
    logic [R5_W-1:0]    r5_reg, r5_next;
    logic               pend_valid_reg, pend_valid_next;
    mps_out_t           pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    mps_out_t           out_reg, out_next;

    logic [ROW_COUNT-1:0] fire;
    logic [CFG_W-1:0]     sel_row;
    logic [ADDR_W-1:0]    slot_byte;
    logic                 out_free;
    logic                 emit_ok;
    logic                 emit_en;
    mps_out_t             emit_data;
    logic                 flush_en;
    logic                 tick_end;
    logic                 slot_done;

    assign fire[0] = 1'b1;
    assign fire[1] = (r1_reg == '0);
    assign fire[2] = (r2_reg == '0);
    assign fire[3] = (r3_reg == '0);
    assign fire[4] = (r4_reg == '0);
    assign fire[5] = (r5_reg == '0);
    assign fire[6] = (tick_reg == '0) || (tick_reg == TICK_W'(ROW6_PERIOD));

    assign sel_row = row_slots[row_reg];

    // slots past the fourth byte read as zero and end the row
    always_comb
    begin
        slot_byte = '0;
        for (int j = 0; j < SLOT_BYTES; j++)
        begin
            if (int'(slot_reg) == j)
            begin
                slot_byte = sel_row[8*j +: 8];
            end
        end
    end

    assign probe_addr = (state_reg == ST_SEEK) ? ADDR_W'(pos_reg) : slot_byte;
    assign slot_done  = (slot_reg == SLOT_W'(SLOTS_PER_ROW - 1));

    assign out_free = !out_valid_reg || !out_stall;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        slot_next   = slot_reg;
        pos_next    = pos_reg;
        cursor_next = cursor_reg;
        toggle_next = toggle_reg;
        emit_en     = 1'b0;
        emit_data   = '{kind: KIND_POLL, device: '0, cmd_slot: 1'b0,
                        device_count: present_count, last: 1'b0};
        flush_en    = 1'b0;
        tick_end    = 1'b0;
        mark        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.func)
                        FUNC_PRESENT, FUNC_ABSENT:
                        begin
                            mark.en   = 1'b1;
                            mark.set  = (in_data.func == FUNC_PRESENT);
                            mark.addr = in_data.addr;
                        end
                        FUNC_NEXT:
                        begin
                            if (present_count == '0)
                            begin
                                emit_en        = 1'b1;
                                emit_data.kind = KIND_NONE;
                                state_next     = ST_FLUSH;
                            end
                            else
                            begin
                                pos_next   = (cursor_reg > AW'(MAX_ADDRESS)) ? '0 : cursor_reg;
                                state_next = ST_SEEK;
                            end
                        end
                        FUNC_TICK:
                        begin
                            row_next   = '0;
                            slot_next  = '0;
                            state_next = ST_SLOT;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SEEK:
            begin
                // a present device exists, so the wrapping search always ends
                if (probe.hit)
                begin
                    emit_en          = 1'b1;
                    emit_data.kind   = KIND_NEXT;
                    emit_data.device = DEV_W'(pos_reg);
                    cursor_next      = (pos_reg == AW'(MAX_ADDRESS)) ? '0 : pos_reg + AW'(1);
                    state_next       = ST_FLUSH;
                end
                else
                begin
                    pos_next = (pos_reg >= AW'(MAX_ADDRESS)) ? '0 : pos_reg + AW'(1);
                end
            end

            ST_SLOT:
            begin
                if (!fire[row_reg])
                begin
                    if (row_reg == ROW_LAST)
                    begin
                        tick_end   = 1'b1;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        row_next  = row_reg + ROW_W'(1);
                        slot_next = '0;
                    end
                end
                else if (!probe.in_range)
                begin
                    state_next = ST_TAIL;
                end
                else if (!probe.hit || emit_ok)
                begin
                    if (probe.hit)
                    begin
                        emit_en          = 1'b1;
                        emit_data.kind   = KIND_POLL;
                        emit_data.device = DEV_W'(slot_byte);
                    end
                    if (slot_done)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end

            ST_TAIL:
            begin
                if (emit_ok || !(row_reg == ROW_CMD || row_reg == ROW_PLUG || row_reg == ROW_SCAN))
                begin
                    if (row_reg == ROW_CMD)
                    begin
                        toggle_next        = ~toggle_reg;
                        emit_en            = 1'b1;
                        emit_data.kind     = KIND_CMD;
                        emit_data.cmd_slot = ~toggle_reg;
                    end
                    else if (row_reg == ROW_PLUG)
                    begin
                        emit_en        = 1'b1;
                        emit_data.kind = KIND_PLUG;
                    end
                    else if (row_reg == ROW_SCAN)
                    begin
                        emit_en        = 1'b1;
                        emit_data.kind = KIND_SCAN;
                    end

                    if (row_reg == ROW_LAST)
                    begin
                        tick_end   = 1'b1;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        row_next   = row_reg + ROW_W'(1);
                        slot_next  = '0;
                        state_next = ST_SLOT;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_en   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // tick counter and its residues move once per tick
    always_comb
    begin
        tick_next = tick_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        r3_next   = r3_reg;
        r4_next   = r4_reg;
        r5_next   = r5_reg;
        if (tick_end)
        begin
            if (fire[6])
            begin
                tick_next = TICK_W'(RESTART);
                r1_next   = R1_RESTART;
                r2_next   = R2_RESTART;
                r3_next   = R3_RESTART;
                r4_next   = R4_RESTART;
                r5_next   = R5_RESTART;
            end
            else
            begin
                tick_next = tick_reg + TICK_W'(1);
                r1_next   = (r1_reg == R1_W'(ROW1_PERIOD - 1)) ? '0 : r1_reg + R1_W'(1);
                r2_next   = (r2_reg == R2_W'(ROW2_PERIOD - 1)) ? '0 : r2_reg + R2_W'(1);
                r3_next   = (r3_reg == R3_W'(ROW3_PERIOD - 1)) ? '0 : r3_reg + R3_W'(1);
                r4_next   = (r4_reg == R4_W'(ROW4_PERIOD - 1)) ? '0 : r4_reg + R4_W'(1);
                r5_next   = (r5_reg == R5_W'(ROW5_PERIOD - 1)) ? '0 : r5_reg + R5_W'(1);
            end
        end
    end

    // one result is held back so the final beat can carry last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_data;
        end
        if (flush_en)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= '0;
            slot_reg       <= '0;
            pos_reg        <= '0;
            cursor_reg     <= '0;
            toggle_reg     <= 1'b0;
            tick_reg       <= '0;
            r1_reg         <= '0;
            r2_reg         <= '0;
            r3_reg         <= '0;
            r4_reg         <= '0;
            r5_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            slot_reg       <= slot_next;
            pos_reg        <= pos_next;
            cursor_reg     <= cursor_next;
            toggle_reg     <= toggle_next;
            tick_reg       <= tick_next;
            r1_reg         <= r1_next;
            r2_reg         <= r2_next;
            r3_reg         <= r3_next;
            r4_reg         <= r4_next;
            r5_reg         <= r5_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/multirate_poll_scheduler_core.sv
`timescale 1ns / 1ps
// multi-rate poll scheduler: presence updates give no beat
// a next request probes one address a cycle and gives its one beat; a tick walks one slot
// a cycle while the output does not stall
// a beat shows in the cycle after the next result is found; the final one, marked last,
// is sent from the flush state once the output is free
// one item at a time; reset clears bitmap, count, tick counter, cursor, toggle and rows

module multirate_poll_scheduler_core #(
    parameter int MAX_ADDRESS   = mps_pkg::MPS_MAX_ADDRESS,
    parameter int SLOTS_PER_ROW = mps_pkg::MPS_SLOTS_PER_ROW
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  mps_pkg::mps_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output mps_pkg::mps_out_t                 out_data,
    input  logic                              cfg_we,
    input  logic [mps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mps_pkg::CFG_W-1:0]         cfg_data
);
    import mps_pkg::*;

    row_bank_t           row_slots_reg;
    mps_mark_t           mark;
    mps_probe_t          probe;
    logic [ADDR_W-1:0]   probe_addr;
    logic [COUNT_W-1:0]  present_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_slots_reg <= '0;
        end
        else if (cfg_we && (cfg_index < CFG_INDEX_W'(ROW_COUNT)))
        begin
            row_slots_reg[cfg_index] <= cfg_data;
        end
    end

    mps_presence #(
        .MAX_ADDRESS (MAX_ADDRESS)
    ) u_presence (
        .clk           (clk),
        .rst_n         (rst_n),
        .mark          (mark),
        .probe_addr    (probe_addr),
        .probe         (probe),
        .present_count (present_count)
    );

    mps_seq #(
        .MAX_ADDRESS   (MAX_ADDRESS),
        .SLOTS_PER_ROW (SLOTS_PER_ROW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .row_slots     (row_slots_reg),
        .present_count (present_count),
        .mark          (mark),
        .probe_addr    (probe_addr),
        .probe         (probe)
    );

endmodule

FILE: rtl/mps_checker.sv
`timescale 1ns / 1ps
// port-level checks for the multi-rate poll scheduler, bound to the top level
// depends on mps_pkg and multirate_poll_scheduler_core

module mps_checker #(
    parameter int MAX_ADDRESS = mps_pkg::MPS_MAX_ADDRESS
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input mps_pkg::mps_in_t                  in_data,
    input logic                              out_valid,
    input logic                              out_stall,
    input mps_pkg::mps_out_t                 out_data
);
    import mps_pkg::*;

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    // a next request always produces a beat, so the block must go busy
    a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.func == FUNC_NEXT |=> in_stall)
        else $error("next request accepted without going busy");

    // only poll and next beats carry an address, and it is never zero
    a_device: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.kind == KIND_POLL || out_data.kind == KIND_NEXT)
                       ? (out_data.device != '0) : (out_data.device == '0)))
        else $error("device field does not match result kind");

    a_cmd_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != KIND_CMD |-> out_data.cmd_slot == 1'b0)
        else $error("command slot set on a non-command beat");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.device_count <= COUNT_W'(MAX_ADDRESS))
        else $error("device count above the address range");

endmodule

bind multirate_poll_scheduler_core mps_checker #(
    .MAX_ADDRESS (MAX_ADDRESS)
) u_mps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for multirate_poll_scheduler_core: a directed table, then random phases,
// each beat checked against a local predictor of the scheduler or a beat given in the table
// depends on rtl/mps_pkg.sv and rtl/multirate_poll_scheduler_core.sv

module tb_top;

    import mps_pkg::*;

    localparam int DRAIN_CYCLES   = 2 * (7 * MPS_SLOTS_PER_ROW + 9) + MPS_MAX_ADDRESS + 3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 50;
    localparam logic [CFG_INDEX_W-1:0] UNUSED_REG = 3'd7;

    localparam mps_out_t NONE_EMPTY = '{KIND_NONE, 6'd0, 1'b0, 6'd0, 1'b1};

    typedef struct packed {
        mps_func_t         func;
        logic [ADDR_W-1:0] addr;
        logic              given;
        mps_out_t          want;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    mps_in_t           in_data;
    logic              out_valid;
    logic              out_stall;
    mps_out_t          out_data;
    logic              cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    // predictor state
    logic [MPS_MAX_ADDRESS:0] present_map;
    logic [COUNT_W-1:0]       present_total;
    logic [TICK_W-1:0]        tick_no;
    logic                     cmd_toggle;
    logic [DEV_W-1:0]         next_cursor;
    logic [CFG_W-1:0]         row_slots [ROW_COUNT];
    int row_period [ROW_COUNT] = '{1, ROW1_PERIOD, ROW2_PERIOD, ROW3_PERIOD,
                                   ROW4_PERIOD, ROW5_PERIOD, ROW6_PERIOD};

    mps_out_t fresh_beats [$];
    mps_out_t expected_beats [$];
    mps_out_t head_beat;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches   = 0;
    int quiet_cycles = 0;

    // slot 0 in the lowest byte; rows stop at a zero or out-of-range slot
    logic [CFG_W-1:0] boot_slots [ROW_COUNT] = '{
        32'h0000_2001, 32'h0521_0203, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0403_0201, 32'h2020_2020, 32'h0300_0005
    };

    plan_row_t plan [26] = '{
        '{FUNC_NEXT,    8'd0,   1'b1, NONE_EMPTY},
        // first tick after reset runs every row and all three row tails
        '{FUNC_TICK,    8'd0,   1'b0, '0},
        '{FUNC_PRESENT, 8'd0,   1'b0, '0},
        '{FUNC_PRESENT, 8'd33,  1'b0, '0},
        '{FUNC_PRESENT, 8'd255, 1'b0, '0},
        '{FUNC_NEXT,    8'd0,   1'b1, NONE_EMPTY},
        '{FUNC_PRESENT, 8'd1,   1'b0, '0},
        '{FUNC_PRESENT, 8'd1,   1'b0, '0},
        '{FUNC_PRESENT, 8'd32,  1'b0, '0},
        '{FUNC_NEXT,    8'd0,   1'b1, '{KIND_NEXT, 6'd1,  1'b0, 6'd2, 1'b1}},
        '{FUNC_NEXT,    8'd0,   1'b1, '{KIND_NEXT, 6'd32, 1'b0, 6'd2, 1'b1}},
        // cursor wrapped past the top address
        '{FUNC_NEXT,    8'd0,   1'b1, '{KIND_NEXT, 6'd1,  1'b0, 6'd2, 1'b1}},
        '{FUNC_PRESENT, 8'd2,   1'b0, '0},
        '{FUNC_PRESENT, 8'd3,   1'b0, '0},
        '{FUNC_TICK,    8'd0,   1'b0, '0},
        '{FUNC_TICK,    8'd0,   1'b0, '0},
        '{FUNC_ABSENT,  8'd2,   1'b0, '0},
        '{FUNC_ABSENT,  8'd2,   1'b0, '0},
        '{FUNC_ABSENT,  8'd0,   1'b0, '0},
        '{FUNC_ABSENT,  8'd200, 1'b0, '0},
        '{FUNC_TICK,    8'd0,   1'b0, '0},
        '{FUNC_ABSENT,  8'd1,   1'b0, '0},
        '{FUNC_ABSENT,  8'd32,  1'b0, '0},
        '{FUNC_ABSENT,  8'd3,   1'b0, '0},
        // row 0 only, all its devices gone: no beat at all
        '{FUNC_TICK,    8'd0,   1'b0, '0},
        '{FUNC_NEXT,    8'd0,   1'b1, NONE_EMPTY}
    };

    multirate_poll_scheduler_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void add_beat(input mps_kind_t kind, input int dev, input logic slot);
        mps_out_t b;
        b.kind         = kind;
        b.device       = DEV_W'(dev);
        b.cmd_slot     = slot;
        b.device_count = present_total;
        b.last         = 1'b0;
        fresh_beats.push_back(b);
    endfunction

    function automatic void predict_item(input mps_in_t it);
        int t;
        int pos;
        int a;
        bit found;
        mps_out_t tail;
        fresh_beats.delete();
        case (it.func)
            FUNC_PRESENT, FUNC_ABSENT:
            begin
                a = it.addr;
                if (a >= 1 && a <= MPS_MAX_ADDRESS)
                begin
                    if (it.func == FUNC_PRESENT && !present_map[a])
                    begin
                        present_map[a] = 1'b1;
                        present_total  = present_total + 1'b1;
                    end
                    else if (it.func == FUNC_ABSENT && present_map[a])
                    begin
                        present_map[a] = 1'b0;
                        present_total  = present_total - 1'b1;
                    end
                end
            end
            FUNC_NEXT:
            begin
                pos   = next_cursor;
                found = 1'b0;
                if (pos > MPS_MAX_ADDRESS)
                    pos = 0;
                if (present_total != 0)
                begin
                    for (int i = 0; i <= MPS_MAX_ADDRESS; i++)
                    begin
                        if (present_map[pos])
                        begin
                            found = 1'b1;
                            break;
                        end
                        pos = (pos >= MPS_MAX_ADDRESS) ? 0 : pos + 1;
                    end
                end
                if (found)
                begin
                    add_beat(KIND_NEXT, pos, 1'b0);
                    next_cursor = DEV_W'((pos >= MPS_MAX_ADDRESS) ? 0 : pos + 1);
                end
                else
                    add_beat(KIND_NONE, 0, 1'b0);
            end
            default:
            begin
                t = tick_no;
                for (int r = 0; r < ROW_COUNT; r++)
                begin
                    if (t % row_period[r] != 0)
                        continue;
                    for (int k = 0; k < MPS_SLOTS_PER_ROW; k++)
                    begin
                        a = (k < SLOT_BYTES) ? int'(row_slots[r][8*k +: 8]) : 0;
                        if (a == 0 || a > MPS_MAX_ADDRESS)
                            break;
                        if (present_map[a])
                            add_beat(KIND_POLL, a, 1'b0);
                    end
                    if (r == ROW_CMD)
                    begin
                        cmd_toggle = ~cmd_toggle;
                        add_beat(KIND_CMD, 0, cmd_toggle);
                    end
                    else if (r == ROW_PLUG)
                        add_beat(KIND_PLUG, 0, 1'b0);
                    else if (r == ROW_SCAN)
                    begin
                        add_beat(KIND_SCAN, 0, 1'b0);
                        t = 1;
                    end
                end
                tick_no = TICK_W'(t + 1);
            end
        endcase
        if (fresh_beats.size() != 0)
        begin
            tail      = fresh_beats.pop_back();
            tail.last = 1'b1;
            fresh_beats.push_back(tail);
        end
    endfunction

    function automatic logic [CFG_W-1:0] random_slots();
        logic [CFG_W-1:0] v;
        int p;
        for (int k = 0; k < SLOT_BYTES; k++)
        begin
            p = $urandom_range(99);
            if (p < 12)
                v[8*k +: 8] = 8'd0;
            else if (p < 24)
                v[8*k +: 8] = 8'($urandom_range(255, MPS_MAX_ADDRESS + 1));
            else if (p < 32)
                v[8*k +: 8] = 8'(MPS_MAX_ADDRESS);
            else
                v[8*k +: 8] = 8'($urandom_range(MPS_MAX_ADDRESS, 1));
        end
        return v;
    endfunction

    // called at a falling edge, returns at the following falling edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx < ROW_COUNT)
            row_slots[idx] = val;
        @(negedge clk);
    endtask

    task automatic write_random_bank();
        for (int r = 0; r < ROW_COUNT; r++)
            write_reg(CFG_INDEX_W'(r), random_slots());
        cfg_we <= 1'b0;
    endtask

    // called at a falling edge; valid is left high, the next call or settle decides
    task automatic send_item(input mps_in_t it, input logic given, input mps_out_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_item(it);
        if (given)
            expected_beats.push_back(want);
        else
            foreach (fresh_beats[i])
                expected_beats.push_back(fresh_beats[i]);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_beats.size() != 0)
            @(negedge clk);
        // presence updates give no beat, so let the core finish quietly
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(input int count);
        mps_in_t it;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 4)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (expected_beats.size() != 0)
                    @(negedge clk);
            end
            sel = $urandom_range(99);
            if (sel < 45)
                it.func = FUNC_TICK;
            else if (sel < 70)
                it.func = FUNC_PRESENT;
            else if (sel < 85)
                it.func = FUNC_ABSENT;
            else
                it.func = FUNC_NEXT;
            if ($urandom_range(99) < 85)
                it.addr = ADDR_W'($urandom_range(MPS_MAX_ADDRESS, 1));
            else
                it.addr = ADDR_W'($urandom_range(255));
            send_item(it, 1'b0, '0);
        end
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: kind %0d device %0d", out_data.kind, out_data.device);
                mismatches++;
            end
            else
            begin
                head_beat = expected_beats.pop_front();
                if (out_data.kind !== head_beat.kind)
                begin
                    $error("kind: expected %0d, got %0d", head_beat.kind, out_data.kind);
                    mismatches++;
                end
                if (out_data.device !== head_beat.device)
                begin
                    $error("device: expected %0d, got %0d", head_beat.device, out_data.device);
                    mismatches++;
                end
                if (out_data.cmd_slot !== head_beat.cmd_slot)
                begin
                    $error("cmd_slot: expected %0d, got %0d",
                           head_beat.cmd_slot, out_data.cmd_slot);
                    mismatches++;
                end
                if (out_data.device_count !== head_beat.device_count)
                begin
                    $error("device_count: expected %0d, got %0d",
                           head_beat.device_count, out_data.device_count);
                    mismatches++;
                end
                if (out_data.last !== head_beat.last)
                begin
                    $error("last: expected %0d, got %0d", head_beat.last, out_data.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0)
            || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        present_map   = '0;
        present_total = '0;
        tick_no       = '0;
        cmd_toggle    = 1'b0;
        next_cursor   = '0;
        foreach (row_slots[r])
            row_slots[r] = '0;
        send_idle_pct = 30;
        recv_idle_pct = 78;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < ROW_COUNT; r++)
            write_reg(CFG_INDEX_W'(r), boot_slots[r]);
        // index past the last row must be ignored
        write_reg(UNUSED_REG, $urandom);
        cfg_we <= 1'b0;

        foreach (plan[i])
            send_item(mps_in_t'{plan[i].func, plan[i].addr}, plan[i].given, plan[i].want);
        settle();

        write_random_bank();
        run_random(RANDOM_ITEMS);
        settle();

        // extremes: all-ones rows stop at once, all-zero rows are empty
        send_idle_pct = 78;
        recv_idle_pct = 30;
        for (int r = 0; r < ROW_COUNT; r++)
            write_reg(CFG_INDEX_W'(r), (r == 0) ? random_slots()
                                       : ((r % 2) ? {CFG_W{1'b1}} : {CFG_W{1'b0}}));
        cfg_we <= 1'b0;
        run_random(RANDOM_ITEMS);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_random_bank();
        run_random(RANDOM_ITEMS);
        settle();

        if (mismatches == 0 && expected_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
